// ===== hdl/lseg_pkg.sv =====
// ---------------------------------------------------------------------------
// lseg_pkg
// shared constants for the led strip effect generator: sizes, register
// indexes, effect codes and base colors
// ---------------------------------------------------------------------------
package lseg_pkg;

	localparam int MAX_PIXELS = 64;
	localparam int IDX_W      = $clog2(MAX_PIXELS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BREATH_INT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BREATH_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_INT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOW_INT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HUE_STEP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HUE_SPACING = 3'd6;

	localparam logic [3:0] OP_OFF          = 4'd0;
	localparam logic [3:0] OP_RED          = 4'd1;
	localparam logic [3:0] OP_WHITE        = 4'd2;
	localparam logic [3:0] OP_BLUE         = 4'd3;
	localparam logic [3:0] OP_GREEN        = 4'd4;
	localparam logic [3:0] OP_SEG_RED      = 4'd5;
	localparam logic [3:0] OP_SEG_WHITE    = 4'd6;
	localparam logic [3:0] OP_SEG_GREEN    = 4'd7;
	localparam logic [3:0] OP_FLASH_RED    = 4'd8;
	localparam logic [3:0] OP_FLASH_WHITE  = 4'd9;
	localparam logic [3:0] OP_FLASH_BLUE   = 4'd10;
	localparam logic [3:0] OP_BREATH_RED   = 4'd11;
	localparam logic [3:0] OP_BREATH_WHITE = 4'd12;
	localparam logic [3:0] OP_RAINBOW      = 4'd13;
	localparam logic [3:0] OP_FLOW         = 4'd14;

	localparam logic [23:0] COLOR_BLACK = 24'h000000;
	localparam logic [23:0] COLOR_RED   = 24'hFF0000;
	localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;
	localparam logic [23:0] COLOR_BLUE  = 24'h0000FF;
	localparam logic [23:0] COLOR_GREEN = 24'h00FF00;

	localparam logic [7:0] WHEEL_SEC1 = 8'd85;
	localparam logic [7:0] WHEEL_SEC2 = 8'd170;

	localparam logic [6:0]  RST_PIXEL_COUNT = 7'd0;
	localparam logic [15:0] RST_BREATH_INT  = 16'd10;
	localparam logic [7:0]  RST_BREATH_STEP = 8'd5;
	localparam logic [15:0] RST_FLASH_INT   = 16'd300;
	localparam logic [15:0] RST_FLOW_INT    = 16'd80;
	localparam logic [7:0]  RST_HUE_STEP    = 8'd8;
	localparam logic [7:0]  RST_HUE_SPACING = 8'd26;

	// three-section color wheel, red to green to blue to red
	function automatic logic [23:0] wheel(input logic [7:0] hue);
		logic [7:0] h;
		logic [7:0] up;
		logic [23:0] c;
		begin
			if (hue < WHEEL_SEC1) begin
				h = hue;
			end else if (hue < WHEEL_SEC2) begin
				h = hue - WHEEL_SEC1;
			end else begin
				h = hue - WHEEL_SEC2;
			end
			up = 8'({h, 1'b0} + {1'b0, h});
			if (hue < WHEEL_SEC1) begin
				c = {8'hFF - up, up, 8'h00};
			end else if (hue < WHEEL_SEC2) begin
				c = {8'h00, 8'hFF - up, up};
			end else begin
				c = {up, 8'h00, 8'hFF - up};
			end
			return c;
		end
	endfunction

	// floor(x / 3) for x below 256, by reciprocal multiply
	function automatic logic [6:0] div3(input logic [7:0] x);
		logic [15:0] p;
		begin
			p = 16'(x) * 16'd171;
			return p[15:9];
		end
	endfunction

endpackage

// ===== hdl/led_strip_effect_generator.sv =====
// ---------------------------------------------------------------------------
// led_strip_effect_generator
// renders at most one frame of strip pixels per request: solid, segment,
// flash, breathing, rainbow, flow; per-effect but flow shares rainbow's timers
// ---------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    operation, segment, now_ms
//  out      out_valid / out_ready  pixel_index, red, green, blue, last_pixel
//  cfg      cfg_we                 cfg_index, cfg_data
//
//  the request is registered in idle, the update state does the timer compare
//  and effect state update, then the pixel sequencer emits one pixel per cycle
//  while out_ready allows; nothing is emitted if the timer has not fired
//  in_ready is high only while the sequencer is idle
//  reset restores register defaults and clears all effect state, no sweep
// ---------------------------------------------------------------------------
module led_strip_effect_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [3:0]                          operation,
	input  logic [1:0]                          segment,
	input  logic [31:0]                         now_ms,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lseg_pkg::IDX_W-1:0]          pixel_index,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue,
	output logic                                last_pixel,
	input  logic                                cfg_we,
	input  logic [lseg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lseg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	localparam logic [lseg_pkg::CNT_W-1:0] CNT_ONE = lseg_pkg::CNT_W'(1);

	state_t st_q;

	logic [6:0]  pixel_count_q;
	logic [15:0] breath_int_q;
	logic [7:0]  breath_step_q;
	logic [15:0] flash_int_q;
	logic [15:0] flow_int_q;
	logic [7:0]  hue_step_q;
	logic [7:0]  hue_spacing_q;

	logic [31:0] rb_time_q;
	logic [7:0]  rb_level_q;
	logic        rb_rising_q;
	logic [31:0] wb_time_q;
	logic [7:0]  wb_level_q;
	logic        wb_rising_q;
	logic [31:0] rf_time_q;
	logic        rf_lit_q;
	logic [31:0] wf_time_q;
	logic        wf_lit_q;
	logic [31:0] bf_time_q;
	logic        bf_lit_q;
	logic [31:0] rainbow_time_q;
	logic [7:0]  rainbow_hue_q;

	logic [3:0]  op_q;
	logic [1:0]  seg_q;
	logic [31:0] now_q;

	logic [lseg_pkg::CNT_W-1:0] n_q;
	logic [lseg_pkg::CNT_W-1:0] lo_q;
	logic [lseg_pkg::CNT_W-1:0] hi_q;
	logic [23:0]                color_q;
	logic                       flow_q;
	logic [7:0]                 hue_q;
	logic [lseg_pkg::IDX_W-1:0] idx_q;

	logic                       out_valid_q;
	logic [lseg_pkg::IDX_W-1:0] pixel_index_q;
	logic [23:0]                rgb_q;
	logic                       last_q;

	// request decode and timer compare
	logic [lseg_pkg::CNT_W-1:0] n_w;
	logic [lseg_pkg::CNT_W-1:0] seg_lo_w;
	logic [lseg_pkg::CNT_W-1:0] seg_hi_w;
	logic [31:0]                stored_w;
	logic [15:0]                interval_w;
	logic [31:0]                diff_w;
	logic                       fire_w;
	logic [7:0]                 lvl_w;
	logic                       rising_w;
	logic signed [9:0]          v_w;
	logic [7:0]                 lvl_new_w;
	logic                       rising_new_w;
	logic [7:0]                 hue_new_w;
	logic                       go_w;
	logic [23:0]                color_w;
	logic [lseg_pkg::CNT_W-1:0] lo_w;
	logic [lseg_pkg::CNT_W-1:0] hi_w;
	logic                       flow_w;

	// pixel datapath
	logic                       pix_in_w;
	logic                       pix_last_w;
	logic [23:0]                pix_rgb_w;
	logic                       load_w;

	always_comb begin
		n_w = (pixel_count_q > lseg_pkg::CNT_W'(lseg_pkg::MAX_PIXELS)) ?
			lseg_pkg::CNT_W'(lseg_pkg::MAX_PIXELS) : pixel_count_q;
		seg_lo_w = '0;
		seg_hi_w = n_w;
		if (seg_q != 2'd0) begin
			seg_lo_w = lseg_pkg::div3(8'(2'(seg_q - 2'd1)) * 8'(n_w));
			seg_hi_w = (seg_q == 2'd3) ? n_w : lseg_pkg::div3(8'(seg_q) * 8'(n_w));
		end

		case (op_q)
			lseg_pkg::OP_FLASH_RED: begin
				stored_w = rf_time_q;
				interval_w = flash_int_q;
			end
			lseg_pkg::OP_FLASH_WHITE: begin
				stored_w = wf_time_q;
				interval_w = flash_int_q;
			end
			lseg_pkg::OP_FLASH_BLUE: begin
				stored_w = bf_time_q;
				interval_w = flash_int_q;
			end
			lseg_pkg::OP_BREATH_RED: begin
				stored_w = rb_time_q;
				interval_w = breath_int_q;
			end
			lseg_pkg::OP_BREATH_WHITE: begin
				stored_w = wb_time_q;
				interval_w = breath_int_q;
			end
			default: begin
				stored_w = rainbow_time_q;
				interval_w = flow_int_q;
			end
		endcase
		diff_w = now_q - stored_w;
		fire_w = (stored_w == 32'd0) || (diff_w >= {16'd0, interval_w});

		lvl_w = (op_q == lseg_pkg::OP_BREATH_WHITE) ? wb_level_q : rb_level_q;
		rising_w = (op_q == lseg_pkg::OP_BREATH_WHITE) ? wb_rising_q : rb_rising_q;
		if (rising_w) begin
			v_w = $signed({2'b00, lvl_w}) + $signed({2'b00, breath_step_q});
		end else begin
			v_w = $signed({2'b00, lvl_w}) - $signed({2'b00, breath_step_q});
		end
		if (v_w >= 10'sd255) begin
			lvl_new_w = 8'hFF;
			rising_new_w = 1'b0;
		end else if (v_w <= 10'sd0) begin
			lvl_new_w = 8'h00;
			rising_new_w = 1'b1;
		end else begin
			lvl_new_w = v_w[7:0];
			rising_new_w = rising_w;
		end

		hue_new_w = rainbow_hue_q + hue_step_q;

		go_w = 1'b0;
		color_w = lseg_pkg::COLOR_BLACK;
		lo_w = '0;
		hi_w = n_w;
		flow_w = 1'b0;
		case (op_q)
			lseg_pkg::OP_OFF: begin
				go_w = 1'b1;
			end
			lseg_pkg::OP_RED: begin
				go_w = 1'b1;
				color_w = lseg_pkg::COLOR_RED;
			end
			lseg_pkg::OP_WHITE: begin
				go_w = 1'b1;
				color_w = lseg_pkg::COLOR_WHITE;
			end
			lseg_pkg::OP_BLUE: begin
				go_w = 1'b1;
				color_w = lseg_pkg::COLOR_BLUE;
			end
			lseg_pkg::OP_GREEN: begin
				go_w = 1'b1;
				color_w = lseg_pkg::COLOR_GREEN;
			end
			lseg_pkg::OP_SEG_RED: begin
				go_w = 1'b1;
				color_w = lseg_pkg::COLOR_RED;
				lo_w = seg_lo_w;
				hi_w = seg_hi_w;
			end
			lseg_pkg::OP_SEG_WHITE: begin
				go_w = 1'b1;
				color_w = lseg_pkg::COLOR_WHITE;
				lo_w = seg_lo_w;
				hi_w = seg_hi_w;
			end
			lseg_pkg::OP_SEG_GREEN: begin
				go_w = 1'b1;
				color_w = lseg_pkg::COLOR_GREEN;
				lo_w = seg_lo_w;
				hi_w = seg_hi_w;
			end
			lseg_pkg::OP_FLASH_RED: begin
				go_w = fire_w;
				color_w = rf_lit_q ? lseg_pkg::COLOR_BLACK : lseg_pkg::COLOR_RED;
				lo_w = seg_lo_w;
				hi_w = seg_hi_w;
			end
			lseg_pkg::OP_FLASH_WHITE: begin
				go_w = fire_w;
				color_w = wf_lit_q ? lseg_pkg::COLOR_BLACK : lseg_pkg::COLOR_WHITE;
			end
			lseg_pkg::OP_FLASH_BLUE: begin
				go_w = fire_w;
				color_w = bf_lit_q ? lseg_pkg::COLOR_BLACK : lseg_pkg::COLOR_BLUE;
			end
			lseg_pkg::OP_BREATH_RED: begin
				go_w = fire_w;
				color_w = {lvl_new_w, 16'h0000};
			end
			lseg_pkg::OP_BREATH_WHITE: begin
				go_w = fire_w;
				color_w = {lvl_new_w, lvl_new_w, lvl_new_w};
				lo_w = seg_lo_w;
				hi_w = seg_hi_w;
			end
			lseg_pkg::OP_RAINBOW: begin
				go_w = fire_w;
				color_w = lseg_pkg::wheel(hue_new_w);
			end
			lseg_pkg::OP_FLOW: begin
				go_w = fire_w;
				flow_w = 1'b1;
			end
			default: begin
				go_w = 1'b0;
			end
		endcase
		if (n_w == 0) begin
			go_w = 1'b0;
		end
	end

	always_comb begin
		pix_in_w = ({1'b0, idx_q} >= lo_q) && ({1'b0, idx_q} < hi_q);
		pix_last_w = (CNT_ONE + {1'b0, idx_q}) == n_q;
		if (flow_q) begin
			pix_rgb_w = lseg_pkg::wheel(hue_q);
		end else begin
			pix_rgb_w = pix_in_w ? color_q : lseg_pkg::COLOR_BLACK;
		end
		load_w = (st_q == ST_EMIT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= lseg_pkg::RST_PIXEL_COUNT;
			breath_int_q <= lseg_pkg::RST_BREATH_INT;
			breath_step_q <= lseg_pkg::RST_BREATH_STEP;
			flash_int_q <= lseg_pkg::RST_FLASH_INT;
			flow_int_q <= lseg_pkg::RST_FLOW_INT;
			hue_step_q <= lseg_pkg::RST_HUE_STEP;
			hue_spacing_q <= lseg_pkg::RST_HUE_SPACING;
		end else if (cfg_we) begin
			case (cfg_index)
				lseg_pkg::CFG_PIXEL_COUNT: pixel_count_q <= cfg_data[6:0];
				lseg_pkg::CFG_BREATH_INT:  breath_int_q <= cfg_data;
				lseg_pkg::CFG_BREATH_STEP: breath_step_q <= cfg_data[7:0];
				lseg_pkg::CFG_FLASH_INT:   flash_int_q <= cfg_data;
				lseg_pkg::CFG_FLOW_INT:    flow_int_q <= cfg_data;
				lseg_pkg::CFG_HUE_STEP:    hue_step_q <= cfg_data[7:0];
				lseg_pkg::CFG_HUE_SPACING: hue_spacing_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rb_time_q <= '0;
			rb_level_q <= '0;
			rb_rising_q <= 1'b1;
			wb_time_q <= '0;
			wb_level_q <= '0;
			wb_rising_q <= 1'b1;
			rf_time_q <= '0;
			rf_lit_q <= 1'b0;
			wf_time_q <= '0;
			wf_lit_q <= 1'b0;
			bf_time_q <= '0;
			bf_lit_q <= 1'b0;
			rainbow_time_q <= '0;
			rainbow_hue_q <= '0;
			op_q <= lseg_pkg::OP_OFF;
			seg_q <= '0;
			now_q <= '0;
			n_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			color_q <= lseg_pkg::COLOR_BLACK;
			flow_q <= 1'b0;
			hue_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			pixel_index_q <= '0;
			rgb_q <= lseg_pkg::COLOR_BLACK;
			last_q <= 1'b0;
		end else begin
			if (out_ready && !load_w) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q <= operation;
						seg_q <= segment;
						now_q <= now_ms;
						st_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					n_q <= n_w;
					lo_q <= lo_w;
					hi_q <= hi_w;
					color_q <= color_w;
					flow_q <= flow_w;
					hue_q <= hue_new_w;
					idx_q <= '0;
					st_q <= go_w ? ST_EMIT : ST_IDLE;
					if (go_w) begin
						case (op_q)
							lseg_pkg::OP_FLASH_RED: begin
								rf_time_q <= now_q;
								rf_lit_q <= !rf_lit_q;
							end
							lseg_pkg::OP_FLASH_WHITE: begin
								wf_time_q <= now_q;
								wf_lit_q <= !wf_lit_q;
							end
							lseg_pkg::OP_FLASH_BLUE: begin
								bf_time_q <= now_q;
								bf_lit_q <= !bf_lit_q;
							end
							lseg_pkg::OP_BREATH_RED: begin
								rb_time_q <= now_q;
								rb_level_q <= lvl_new_w;
								rb_rising_q <= rising_new_w;
							end
							lseg_pkg::OP_BREATH_WHITE: begin
								wb_time_q <= now_q;
								wb_level_q <= lvl_new_w;
								wb_rising_q <= rising_new_w;
							end
							lseg_pkg::OP_RAINBOW, lseg_pkg::OP_FLOW: begin
								rainbow_time_q <= now_q;
								rainbow_hue_q <= hue_new_w;
							end
							default: begin
							end
						endcase
					end
				end
				ST_EMIT: begin
					if (load_w) begin
						out_valid_q <= 1'b1;
						pixel_index_q <= idx_q;
						rgb_q <= pix_rgb_w;
						last_q <= pix_last_w;
						idx_q <= idx_q + 1'b1;
						hue_q <= hue_q + hue_spacing_q;
						if (pix_last_w) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign pixel_index = pixel_index_q;
	assign red = rgb_q[23:16];
	assign green = rgb_q[15:8];
	assign blue = rgb_q[7:0];
	assign last_pixel = last_q;

`ifndef SYNTH
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT) |-> ({1'b0, idx_q} < n_q))
		else $error("pixel counter beyond frame length");

	a_request_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (st_q == ST_UPDATE))
		else $error("accepted request did not start an update");

	a_update_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_UPDATE) |=> (st_q != ST_UPDATE) && !in_ready ||
			(st_q == ST_IDLE))
		else $error("update lasted more than one cycle");

	a_no_ready_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT) |-> !in_ready)
		else $error("request accepted during pixel emission");
`endif

endmodule
